// ===== rtl/core/rti_pkg.sv =====
`default_nettype none
package rti_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// operand width of vectors, capped at 32 bits
	localparam int CW    = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int PW    = 2 * CW - FB;      // floored product
	localparam int DW    = PW + 2;           // dot product
	localparam int AW    = DW + 1;           // dot product after sign flip
	localparam int RW    = AW + 1;           // divider remainder
	localparam int T_W   = 31;               // distance width
	localparam int LB    = T_W - FB;         // numerator bits above the fraction
	localparam int EPS_W = 16;

	localparam int IN_DW  = ((6 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_DW = ((T_W + 7) / 8) * 8;

	localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

	// miss reasons
	localparam logic [2:0] R_HIT      = 3'd0;
	localparam logic [2:0] R_PARALLEL = 3'd1;
	localparam logic [2:0] R_U_OUT    = 3'd2;
	localparam logic [2:0] R_V_OUT    = 3'd3;
	localparam logic [2:0] R_T_SMALL  = 3'd4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RAY  = 1'b1;
	localparam logic [1:0] VSEL_NONE = 2'd3;

	localparam logic [2:0] ADDR_EPS = 3'd0;

	typedef logic signed [CW-1:0] vec_t [3];

	typedef struct packed {
		logic [2:0] reason;
		logic       nt_pos;
		logic       t_sat;
	} rti_tag_t;

	typedef struct packed {
		logic [AW-1:0]  den;
		logic [RW-1:0]  rem;
		logic [T_W-1:0] quo;
		logic [T_W-1:0] nb;
		rti_tag_t       tag;
	} rti_div_t;

	localparam logic signed [COORD_WIDTH:0] E_HI =
		{{(COORD_WIDTH + 2 - CW){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [COORD_WIDTH:0] E_LO = ~E_HI;
	localparam logic signed [PW:0] X_HI = {{(PW + 2 - CW){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [PW:0] X_LO = ~X_HI;

	function automatic logic signed [CW-1:0] sat_e(input logic signed [COORD_WIDTH:0] x);
		logic signed [CW-1:0] r;
		if (x > E_HI)
			r = E_HI[CW-1:0];
		else if (x < E_LO)
			r = E_LO[CW-1:0];
		else
			r = x[CW-1:0];
		return r;
	endfunction

	function automatic logic signed [CW-1:0] sat_x(input logic signed [PW:0] x);
		logic signed [CW-1:0] r;
		if (x > X_HI)
			r = X_HI[CW-1:0];
		else if (x < X_LO)
			r = X_LO[CW-1:0];
		else
			r = x[CW-1:0];
		return r;
	endfunction

	// product floored by the fraction bits
	function automatic logic signed [PW-1:0] mulq(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = (2*CW)'(a) * (2*CW)'(b);
		return p[2*CW-1:FB];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rti_geom.sv =====
`default_nettype none
module rti_geom import rti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  wire logic signed [COORD_WIDTH-1:0] org [3],
	input  wire logic signed [COORD_WIDTH-1:0] dir [3],
	input  wire logic signed [COORD_WIDTH-1:0] vtx [9],
	output logic out_vld,
	output logic signed [DW-1:0] a,
	output logic signed [DW-1:0] nu,
	output logic signed [DW-1:0] nv,
	output logic signed [DW-1:0] nt
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	vec_t dir_s1, e1_s1, e2_s1, s_s1;
	vec_t dir_s2, e1_s2, e2_s2, s_s2;
	vec_t dir_s3, e1_s3, e2_s3, s_s3, h_s3, q_s3;
	logic signed [PW-1:0] ph_s2 [6];
	logic signed [PW-1:0] pq_s2 [6];
	logic signed [PW-1:0] pa_s4 [3];
	logic signed [PW-1:0] pu_s4 [3];
	logic signed [PW-1:0] pv_s4 [3];
	logic signed [PW-1:0] pt_s4 [3];
	logic signed [DW-1:0] a_s5, nu_s5, nv_s5, nt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				dir_s1[k] <= sat_e($signed({dir[k][COORD_WIDTH-1], dir[k]}));
				e1_s1[k]  <= sat_e($signed({vtx[3+k][COORD_WIDTH-1], vtx[3+k]})
					- $signed({vtx[k][COORD_WIDTH-1], vtx[k]}));
				e2_s1[k]  <= sat_e($signed({vtx[6+k][COORD_WIDTH-1], vtx[6+k]})
					- $signed({vtx[k][COORD_WIDTH-1], vtx[k]}));
				s_s1[k]   <= sat_e($signed({org[k][COORD_WIDTH-1], org[k]})
					- $signed({vtx[k][COORD_WIDTH-1], vtx[k]}));
			end

			// h = dir x e2, q = s x e1
			ph_s2[0] <= mulq(dir_s1[1], e2_s1[2]);
			ph_s2[1] <= mulq(dir_s1[2], e2_s1[1]);
			ph_s2[2] <= mulq(dir_s1[2], e2_s1[0]);
			ph_s2[3] <= mulq(dir_s1[0], e2_s1[2]);
			ph_s2[4] <= mulq(dir_s1[0], e2_s1[1]);
			ph_s2[5] <= mulq(dir_s1[1], e2_s1[0]);
			pq_s2[0] <= mulq(s_s1[1], e1_s1[2]);
			pq_s2[1] <= mulq(s_s1[2], e1_s1[1]);
			pq_s2[2] <= mulq(s_s1[2], e1_s1[0]);
			pq_s2[3] <= mulq(s_s1[0], e1_s1[2]);
			pq_s2[4] <= mulq(s_s1[0], e1_s1[1]);
			pq_s2[5] <= mulq(s_s1[1], e1_s1[0]);
			dir_s2 <= dir_s1;
			e1_s2  <= e1_s1;
			e2_s2  <= e2_s1;
			s_s2   <= s_s1;

			for (int k = 0; k < 3; k++) begin
				h_s3[k] <= sat_x($signed({ph_s2[2*k][PW-1], ph_s2[2*k]})
					- $signed({ph_s2[2*k+1][PW-1], ph_s2[2*k+1]}));
				q_s3[k] <= sat_x($signed({pq_s2[2*k][PW-1], pq_s2[2*k]})
					- $signed({pq_s2[2*k+1][PW-1], pq_s2[2*k+1]}));
			end
			dir_s3 <= dir_s2;
			e1_s3  <= e1_s2;
			e2_s3  <= e2_s2;
			s_s3   <= s_s2;

			for (int k = 0; k < 3; k++) begin
				pa_s4[k] <= mulq(e1_s3[k], h_s3[k]);
				pu_s4[k] <= mulq(s_s3[k], h_s3[k]);
				pv_s4[k] <= mulq(dir_s3[k], q_s3[k]);
				pt_s4[k] <= mulq(e2_s3[k], q_s3[k]);
			end

			a_s5  <= DW'(pa_s4[0]) + DW'(pa_s4[1]) + DW'(pa_s4[2]);
			nu_s5 <= DW'(pu_s4[0]) + DW'(pu_s4[1]) + DW'(pu_s4[2]);
			nv_s5 <= DW'(pv_s4[0]) + DW'(pv_s4[1]) + DW'(pv_s4[2]);
			nt_s5 <= DW'(pt_s4[0]) + DW'(pt_s4[1]) + DW'(pt_s4[2]);
		end
	end

	assign out_vld = vld_s5;
	assign a  = a_s5;
	assign nu = nu_s5;
	assign nv = nv_s5;
	assign nt = nt_s5;

endmodule
`default_nettype wire

// ===== rtl/core/rti_class.sv =====
`default_nettype none
module rti_class import rti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic [EPS_W-1:0] eps,
	input  wire logic in_vld,
	input  wire logic signed [DW-1:0] a,
	input  wire logic signed [DW-1:0] nu,
	input  wire logic signed [DW-1:0] nv,
	input  wire logic signed [DW-1:0] nt,
	output logic out_vld,
	output rti_div_t out_div
);

	logic vld_s6, vld_s7;
	logic signed [AW-1:0] a_s6, nu_s6, nv_s6, nt_s6;
	rti_div_t div_s7;

	logic signed [AW:0] sum_uv;
	logic par;
	logic [2:0] reason;
	logic [AW+LB-1:0] nt_w, a_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= in_vld;
			vld_s7 <= vld_s6;
		end
	end

	// take the magnitude of the determinant, folding its sign into the numerators
	always_ff @(posedge clk) begin
		if (en) begin
			if (a < 0) begin
				a_s6  <= -AW'(a);
				nu_s6 <= -AW'(nu);
				nv_s6 <= -AW'(nv);
				nt_s6 <= -AW'(nt);
			end else begin
				a_s6  <= AW'(a);
				nu_s6 <= AW'(nu);
				nv_s6 <= AW'(nv);
				nt_s6 <= AW'(nt);
			end
		end
	end

	always_comb begin
		sum_uv = (AW+1)'(nu_s6) + (AW+1)'(nv_s6);
		par = (a_s6 == '0) || (a_s6 < $signed(AW'(eps)));
		if (par)
			reason = R_PARALLEL;
		else if (nu_s6 < 0 || nu_s6 > a_s6)
			reason = R_U_OUT;
		else if (nv_s6 < 0 || sum_uv > (AW+1)'(a_s6))
			reason = R_V_OUT;
		else
			reason = R_HIT;
		nt_w = {{LB{1'b0}}, nt_s6};
		a_w  = {a_s6, {LB{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s7.tag.reason <= reason;
			div_s7.tag.nt_pos <= !nt_s6[AW-1] && (nt_s6 != '0);
			div_s7.tag.t_sat  <= nt_w >= a_w;
			div_s7.den <= a_s6;
			div_s7.rem <= RW'(nt_s6[AW-1:LB]);
			div_s7.quo <= '0;
			div_s7.nb  <= {nt_s6[LB-1:0], {FB{1'b0}}};
		end
	end

	assign out_vld = vld_s7;
	assign out_div = div_s7;

endmodule
`default_nettype wire

// ===== rtl/core/rti_div.sv =====
`default_nettype none
module rti_div import rti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_vld,
	input  rti_div_t  in_div,
	output logic out_vld,
	output rti_div_t out_div
);

	// one restoring quotient bit per stage
	logic     vld_q [T_W+1];
	rti_div_t st_q  [T_W+1];

	assign vld_q[0] = in_vld;
	assign st_q[0]  = in_div;

	for (genvar i = 0; i < T_W; i++) begin : g_stage
		logic [RW-1:0] r2;
		logic          ge;

		always_comb begin
			r2 = {st_q[i].rem[RW-2:0], st_q[i].nb[T_W-1]};
			ge = r2 >= RW'(st_q[i].den);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[i+1] <= 1'b0;
			else if (en)
				vld_q[i+1] <= vld_q[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_q[i+1].den <= st_q[i].den;
				st_q[i+1].rem <= ge ? r2 - RW'(st_q[i].den) : r2;
				st_q[i+1].quo <= {st_q[i].quo[T_W-2:0], ge};
				st_q[i+1].nb  <= {st_q[i].nb[T_W-2:0], 1'b0};
				st_q[i+1].tag <= st_q[i].tag;
			end
		end
	end

	assign out_vld = vld_q[T_W];
	assign out_div = st_q[T_W];

endmodule
`default_nettype wire

// ===== rtl/core/ray_triangle_intersect.sv =====
// Moller-Trumbore ray/triangle test in signed Q16.16. Load transactions
// (tuser op = 0) write one vertex (none if vertex_sel is 3) and give no
// result; ray transactions give one result each, in order. One transaction
// is taken every cycle unless back-pressure on the result side stalls the
// whole pipe. A ray passes five geometry stages (edges, cross-product
// multiplies, cross saturation, dot multiplies, dot sums), two
// classification stages, a 31-stage restoring divider producing one bit of
// t per stage, and the output register. A vertex load is seen by every ray
// accepted after it. Test rays only once all three vertices have been
// loaded. epsilon (address 0) may be written only while no ray is in flight.
`default_nettype none
module ray_triangle_intersect import rti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// px, py, pz, dx, dy, dz
	input  wire logic [IN_DW-1:0] s_tdata,
	// op, vertex_sel[1:0]
	input  wire logic [2:0] s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// distance[30:0], zero pad
	output logic [OUT_DW-1:0] m_tdata,
	// hit, miss_reason[2:0]
	output logic [3:0] m_tuser,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic en, acc, ray_vld;
	logic [EPS_W-1:0] eps_q;
	logic signed [COORD_WIDTH-1:0] vtx_q [9];
	logic signed [COORD_WIDTH-1:0] org [3];
	logic signed [COORD_WIDTH-1:0] dir [3];
	logic op;
	logic [1:0] vsel;

	logic geo_vld, cls_vld, div_vld;
	logic signed [DW-1:0] a, nu, nv, nt;
	rti_div_t cls_div, div_out;

	logic [T_W-1:0] t;
	logic [2:0] reason;
	logic hit_s, vld_o_s;
	logic [T_W-1:0] dist_s;
	logic [2:0] reason_s;

	assign en       = !vld_o_s || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && s_tready;
	assign op       = s_tuser[0];
	assign vsel     = s_tuser[2:1];
	assign ray_vld  = acc && (op == OP_RAY);

	for (genvar k = 0; k < 3; k++) begin : g_unpack
		assign org[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
		assign dir[k] = s_tdata[(k+3)*COORD_WIDTH +: COORD_WIDTH];
	end

	always_ff @(posedge clk) begin
		if (acc && op == OP_LOAD && vsel != VSEL_NONE) begin
			for (int i = 0; i < 3; i++)
				if (vsel == 2'(i))
					for (int k = 0; k < 3; k++)
						vtx_q[3*i+k] <= org[k];
		end
	end

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= EPS_RESET;
		else if (psel && penable && pwrite && paddr == ADDR_EPS)
			eps_q <= pwdata[EPS_W-1:0];
	end

	assign prdata = (paddr == ADDR_EPS) ? 32'(eps_q) : '0;

	rti_geom u_geom (
		.clk, .arst_n, .en,
		.in_vld(ray_vld), .org, .dir, .vtx(vtx_q),
		.out_vld(geo_vld), .a, .nu, .nv, .nt
	);

	rti_class u_class (
		.clk, .arst_n, .en, .eps(eps_q),
		.in_vld(geo_vld), .a, .nu, .nv, .nt,
		.out_vld(cls_vld), .out_div(cls_div)
	);

	rti_div u_div (
		.clk, .arst_n, .en,
		.in_vld(cls_vld), .in_div(cls_div),
		.out_vld(div_vld), .out_div(div_out)
	);

	always_comb begin
		if (!div_out.tag.nt_pos)
			t = '0;
		else if (div_out.tag.t_sat)
			t = T_MAX;
		else
			t = div_out.quo;
		reason = div_out.tag.reason;
		if (reason == R_HIT && t <= T_W'(eps_q))
			reason = R_T_SMALL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o_s <= 1'b0;
		else if (en)
			vld_o_s <= div_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s    <= reason == R_HIT;
			dist_s   <= (reason == R_HIT) ? t : '0;
			reason_s <= reason;
		end
	end

	assign m_tvalid = vld_o_s;
	assign m_tdata  = OUT_DW'(dist_s);
	assign m_tuser  = {reason_s, hit_s};

endmodule
`default_nettype wire

// ===== rtl/core/rti_checker.sv =====
`default_nettype none
module rti_checker import rti_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [OUT_DW-1:0] m_tdata,
	input wire logic [3:0] m_tuser
);

	default clocking cb @(posedge clk); endclocking

	a_hold: assert property (disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_hit_reason: assert property (disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tuser[3:1] == R_HIT)))
		else $error("hit flag and miss reason disagree");

	a_miss_zero: assert property (disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("nonzero distance on a miss");

	a_ready: assert property (disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output side");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ===== test/ray_triangle_intersect_tb.sv =====
`timescale 1ns / 100ps
module ray_triangle_intersect_tb;
	import rti_pkg::*;

	typedef struct packed {
		bit            op;
		bit [1:0]      sel;
		bit [5:0][31:0] w;   // px, py, pz, dx, dy, dz
	} ray_item_t;

	typedef struct packed {
		bit        hit;
		bit [30:0] tdist;
		bit [2:0]  why;
	} hit_res_t;

	localparam longint CRANGE = 64 * 65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DW-1:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic [3:0] m_tuser;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ray_triangle_intersect uut (.*);

	ray_item_t pending_q[$];
	hit_res_t  hits_q[$];
	ray_item_t cur_item;
	bit        taken = 1'b0;
	int        gap_pct = 0, stall_pct = 0;
	bit        hold_req = 1'b0;
	int        hold_cnt = 0;
	int        errors = 0;

	// predictor state
	longint    vstore[9];
	longint    eps_cfg = 7;
	// generator's view of the triangle
	longint    tri_v[9];

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint fmul(longint a, longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic longint xprod(longint a1, longint b2, longint a2, longint b1);
		return sat32(fmul(a1, b2) - fmul(a2, b1));
	endfunction

	function automatic longint unsigned t_quot(longint unsigned n, longint unsigned d);
		longint unsigned ip, r, fr;
		ip = n / d;
		r = n % d;
		fr = 0;
		if (ip >= (64'd1 << (31 - FRAC_BITS))) return 64'(T_MAX);
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r << 1;
			fr = fr << 1;
			if (r >= d) begin
				r = r - d;
				fr = fr | 1;
			end
		end
		return (ip << FRAC_BITS) | fr;
	endfunction

	function automatic hit_res_t trace_ray(ray_item_t it);
		longint dv[3], e1[3], e2[3], s[3], h[3], q[3];
		longint a, nu, nv, nt;
		longint unsigned t;
		hit_res_t r;
		t = 0;
		r.why = R_HIT;
		for (int k = 0; k < 3; k++) begin
			dv[k] = longint'($signed(it.w[3+k]));
			e1[k] = sat32(vstore[3+k] - vstore[k]);
			e2[k] = sat32(vstore[6+k] - vstore[k]);
			s[k] = sat32(longint'($signed(it.w[k])) - vstore[k]);
		end
		h[0] = xprod(dv[1], e2[2], dv[2], e2[1]);
		h[1] = xprod(dv[2], e2[0], dv[0], e2[2]);
		h[2] = xprod(dv[0], e2[1], dv[1], e2[0]);
		a = fmul(e1[0], h[0]) + fmul(e1[1], h[1]) + fmul(e1[2], h[2]);
		if (a == 0 || (a > -eps_cfg && a < eps_cfg)) begin
			r.why = R_PARALLEL;
		end else begin
			q[0] = xprod(s[1], e1[2], s[2], e1[1]);
			q[1] = xprod(s[2], e1[0], s[0], e1[2]);
			q[2] = xprod(s[0], e1[1], s[1], e1[0]);
			nu = fmul(s[0], h[0]) + fmul(s[1], h[1]) + fmul(s[2], h[2]);
			nv = fmul(dv[0], q[0]) + fmul(dv[1], q[1]) + fmul(dv[2], q[2]);
			nt = fmul(e2[0], q[0]) + fmul(e2[1], q[1]) + fmul(e2[2], q[2]);
			if (a < 0) begin
				a = -a;
				nu = -nu;
				nv = -nv;
				nt = -nt;
			end
			if (nu < 0 || nu > a)
				r.why = R_U_OUT;
			else if (nv < 0 || nu + nv > a)
				r.why = R_V_OUT;
			else begin
				if (nt > 0) t = t_quot(nt, a);
				if (t <= longint'(eps_cfg)) r.why = R_T_SMALL;
			end
		end
		r.hit = (r.why == R_HIT);
		r.tdist = r.hit ? t[30:0] : '0;
		return r;
	endfunction

	// input side
	always @(posedge clk) begin
		taken = s_tvalid && s_tready;
		if (taken) begin
			if (cur_item.op == OP_LOAD) begin
				if (cur_item.sel != VSEL_NONE)
					for (int k = 0; k < 3; k++)
						vstore[cur_item.sel*3+k] = longint'($signed(cur_item.w[k]));
			end else
				hits_q.push_back(trace_ray(cur_item));
		end
	end

	always @(negedge clk) begin
		if (!(s_tvalid && !taken)) begin
			if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
				cur_item = pending_q.pop_front();
				s_tdata <= cur_item.w;
				s_tuser <= {cur_item.sel, cur_item.op};
				s_tvalid <= 1'b1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// output side
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		hit_res_t want;
		if (m_tvalid && m_tready) begin
			if (hits_q.size() == 0) begin
				$display("%0t: unexpected result transaction hit=%0d dist=%h why=%0d",
					$time, m_tuser[0], m_tdata[30:0], m_tuser[3:1]);
				errors++;
			end else begin
				want = hits_q.pop_front();
				if (m_tuser[0] !== want.hit) begin
					$display("%0t: hit expected %0d actual %0d", $time, want.hit, m_tuser[0]);
					errors++;
				end
				if (m_tdata[30:0] !== want.tdist) begin
					$display("%0t: distance expected %h actual %h",
						$time, want.tdist, m_tdata[30:0]);
					errors++;
				end
				if (m_tuser[3:1] !== want.why) begin
					$display("%0t: miss_reason expected %0d actual %0d",
						$time, want.why, m_tuser[3:1]);
					errors++;
				end
			end
		end
	end

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (addr == ADDR_EPS) eps_cfg = data[15:0];
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || s_tvalid || hits_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic ray_item_t vload(bit [1:0] sel, longint x, longint y, longint z);
		ray_item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.sel = sel;
		it.w[0] = x[31:0];
		it.w[1] = y[31:0];
		it.w[2] = z[31:0];
		if (sel != VSEL_NONE) begin
			tri_v[sel*3] = longint'($signed(x[31:0]));
			tri_v[sel*3+1] = longint'($signed(y[31:0]));
			tri_v[sel*3+2] = longint'($signed(z[31:0]));
		end
		return it;
	endfunction

	function automatic ray_item_t ray(longint ox, longint oy, longint oz,
			longint ddx, longint ddy, longint ddz);
		ray_item_t it;
		it = '0;
		it.op = OP_RAY;
		it.sel = 2'($urandom);
		it.w[0] = ox[31:0];
		it.w[1] = oy[31:0];
		it.w[2] = oz[31:0];
		it.w[3] = ddx[31:0];
		it.w[4] = ddy[31:0];
		it.w[5] = ddz[31:0];
		return it;
	endfunction

	function automatic longint coord();
		return longint'($urandom_range(0, 2 * CRANGE)) - CRANGE;
	endfunction

	function automatic ray_item_t random_item();
		ray_item_t it;
		longint u, v, pt[3], org[3], dv[3];
		int pick, sh;
		pick = $urandom_range(99);
		if (pick < 7)
			return vload(2'($urandom_range(0, 2)), coord(), coord(), coord());
		if (pick < 9) begin
			it = vload(VSEL_NONE, 0, 0, 0);
			it.w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return it;
		end
		if (pick < 10)
			return vload(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
		if (pick < 20) begin
			it = ray(0, 0, 0, 0, 0, 0);
			it.w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return it;
		end
		// aimed at a point of the triangle's plane, mostly inside
		if ($urandom_range(3) == 0) begin
			u = longint'($urandom_range(0, 90000)) - 12000;
			v = longint'($urandom_range(0, 90000)) - 12000;
		end else begin
			u = $urandom_range(0, 65536);
			v = $urandom_range(0, 65536 - u);
		end
		sh = $urandom_range(0, 5);
		for (int k = 0; k < 3; k++) begin
			pt[k] = tri_v[k] + (((tri_v[3+k] - tri_v[k]) * u
				+ (tri_v[6+k] - tri_v[k]) * v) >>> FRAC_BITS);
			org[k] = pt[k] + coord() / 2;
			dv[k] = (pt[k] - org[k]) >>> sh;
			if ($urandom_range(7) == 0) dv[k] = dv[k] <<< 3;
		end
		if ($urandom_range(9) == 0)
			for (int k = 0; k < 3; k++) dv[k] = -dv[k];
		return ray(org[0], org[1], org[2], dv[0], dv[1], dv[2]);
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) pending_q.push_back(random_item());
	endtask

	localparam longint ONE = 65536;

	initial begin
		for (int k = 0; k < 9; k++) begin
			vstore[k] = 0;
			tri_v[k] = 0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		gap_pct = 19;
		stall_pct = 82;
		pending_q.push_back(vload(2'd0, 0, 0, 0));
		pending_q.push_back(vload(2'd1, ONE, 0, 0));
		pending_q.push_back(vload(2'd2, 0, ONE, 0));
		pending_q.push_back(vload(VSEL_NONE, -1, -1, -1));
		pending_q.push_back(ray(ONE/4, ONE/4, ONE, 0, 0, -ONE));          // hit
		pending_q.push_back(ray(ONE/4, ONE/4, -ONE, 0, 0, -ONE));         // behind
		pending_q.push_back(ray(ONE/4, ONE/4, ONE, ONE, 0, 0));           // parallel
		pending_q.push_back(ray(ONE/4, ONE/4, ONE, 0, 0, 0));             // zero det
		pending_q.push_back(ray(2*ONE, ONE/4, ONE, 0, 0, -ONE));          // u out
		pending_q.push_back(ray(-ONE/4, ONE/4, ONE, 0, 0, -ONE));         // u neg
		pending_q.push_back(ray(ONE/4, -ONE/4, ONE, 0, 0, -ONE));         // v neg
		pending_q.push_back(ray(3*ONE/4, 3*ONE/4, ONE, 0, 0, -ONE));      // u+v > 1
		pending_q.push_back(ray(ONE/4, ONE/4, 0, 0, 0, -ONE));            // t zero
		pending_q.push_back(ray(ONE/4, ONE/4, 3, 0, 0, -ONE));            // t tiny
		pending_q.push_back(ray(ONE/4, ONE/4, 30000*ONE, 0, 0, -1));      // huge t
		pending_q.push_back(ray(ONE/4, ONE/4, ONE, 0, 0, -64'sd2147483648));
		pending_q.push_back(ray(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
			64'sd2147483647, -64'sd2147483648, 64'sd2147483647));
		pending_q.push_back(ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648));
		pending_q.push_back(ray(0, 0, 0, 0, 0, 0));
		// reversed winding, negative determinant
		pending_q.push_back(vload(2'd1, 0, ONE, 0));
		pending_q.push_back(vload(2'd2, ONE, 0, 0));
		pending_q.push_back(ray(ONE/4, ONE/4, ONE, 0, 0, -ONE));
		pending_q.push_back(ray(ONE/4, ONE/4, -ONE, 0, 0, ONE));
		// extreme vertex coordinates saturate the cross product
		pending_q.push_back(vload(2'd2, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647));
		pending_q.push_back(ray(ONE, ONE, ONE, -ONE, -ONE, -ONE));
		pending_q.push_back(vload(2'd2, ONE, ONE, 0));
		drain();

		apb_write(ADDR_EPS, 32'd0);
		run_random(450);
		drain();

		// sender pauses above until everything came back; now the other mix
		gap_pct = 82;
		stall_pct = 19;
		apb_write(ADDR_EPS, 32'd65535);
		run_random(250);
		drain();

		gap_pct = 0;
		stall_pct = 0;
		apb_write(ADDR_EPS, 32'($urandom_range(0, 65535)));
		run_random(400);
		while (pending_q.size() > 320) @(posedge clk);
		hold_req = 1'b1;
		drain();

		apb_write(ADDR_EPS, 32'd7);
		run_random(350);
		drain();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
